[src/sma_pkg.sv]
// ----------------------------------------------------------------------------
// sma_pkg
// Shared constants for the moving average crossover block: register
// indexes, reset values, field widths and signal codes.
// ----------------------------------------------------------------------------
package sma_pkg;

  // Configuration register data and index widths
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PERIOD  = CFG_IDX_W'(1);

  // Register reset values
  localparam logic [CFG_W-1:0] SHORT_PERIOD_RST = CFG_W'(10);
  localparam logic [CFG_W-1:0] LONG_PERIOD_RST  = CFG_W'(50);

  // Output signal codes
  localparam int SIG_W = 2;
  localparam logic signed [SIG_W-1:0] SIG_ABOVE = 2'sb01;
  localparam logic signed [SIG_W-1:0] SIG_BELOW = 2'sb11;
  localparam logic signed [SIG_W-1:0] SIG_NONE  = 2'sb00;

endpackage

[src/sma_if.sv]
// ----------------------------------------------------------------------------
// sma_if
// Valid/ready channels of the crossover block: price requests in,
// signal requests out, and register writes.
// ----------------------------------------------------------------------------
interface sma_price_if #(
  parameter int PRICE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [PRICE_WIDTH-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

interface sma_signal_if
  import sma_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [SIG_W-1:0] signal;

  modport source (output valid, output signal, input ready);
  modport sink   (input valid, input signal, output ready);
endinterface

interface sma_cfg_if
  import sma_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/sma_cell.sv]
// ----------------------------------------------------------------------------
// sma_cell
// One cell of the prefix sum chain. On a new price it loads the price
// plus the sum its upstream neighbor held, so once k+1 prices have
// entered, cell k holds the sum of the newest k+1 prices.
// ----------------------------------------------------------------------------
module sma_cell #(
  parameter int SUM_W = 38
) (
  input  logic             clk,
  input  logic             shift_en,
  input  logic [SUM_W-1:0] price_i,
  input  logic [SUM_W-1:0] sum_prev_i,
  output logic [SUM_W-1:0] sum_o
);

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;

  // Take the new price on top of the neighbor's old prefix
  assign sum_nxt = price_i + sum_prev_i;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_o = sum_r;

endmodule

[src/sma_cmp.sv]
// ----------------------------------------------------------------------------
// sma_cmp
// Cross-multiply stage: scales each window sum by the other window's
// period, registers the products and compares them.
// ----------------------------------------------------------------------------
module sma_cmp
  import sma_pkg::*;
#(
  parameter int SUM_W = 38
) (
  input  logic                    clk,
  input  logic                    adv,
  input  logic [SUM_W-1:0]        short_sum_i,
  input  logic [SUM_W-1:0]        long_sum_i,
  input  logic [CFG_W-1:0]        short_per_i,
  input  logic [CFG_W-1:0]        long_per_i,
  input  logic                    active_i,
  output logic signed [SIG_W-1:0] sig_o
);

  localparam int PROD_W = SUM_W + CFG_W;

  logic [PROD_W-1:0] prod_a_r, prod_a_nxt;
  logic [PROD_W-1:0] prod_b_r, prod_b_nxt;
  logic              active_r;

  // Cross-multiply the sums with the opposite periods
  assign prod_a_nxt = PROD_W'(short_sum_i) * PROD_W'(long_per_i);
  assign prod_b_nxt = PROD_W'(long_sum_i) * PROD_W'(short_per_i);

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
      active_r <= active_i;
    end
  end

  // Compare, and hold zero until more prices than the long period have entered
  always_comb begin
    if (!active_r) begin
      sig_o = SIG_NONE;
    end else if (prod_a_r > prod_b_r) begin
      sig_o = SIG_ABOVE;
    end else if (prod_a_r < prod_b_r) begin
      sig_o = SIG_BELOW;
    end else begin
      sig_o = SIG_NONE;
    end
  end

endmodule

[src/sma_crossover_signal_top.sv]
// ----------------------------------------------------------------------------
// sma_crossover_signal_top
// Dual simple moving average crossover over a chain of prefix sum cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   carries one price per request; out_if returns one signal per
//   price (+1 short average above long, -1 below, 0 equal or not yet
//   warmed up). cfg_if writes short_period (index 0) and long_period
//   (index 1); it is always ready, and writes belong to idle periods.
//   Throughput is one price per cycle while out_if is not stalled:
//   every cell adds the new price to its neighbor's sum, so the whole
//   window update is one add per cell. The cells update at the
//   accepting edge; the window tap select register, the cross-multiply
//   register and the output register then follow in that order before
//   the result appears on out_if.
//   The pipeline advances as a whole; when out_if is stalled with a result
//   waiting, in_if drops ready and every stage holds.
//   Synchronous reset clears the sample count, the valid bits and restores
//   the periods to 10 and 50. The cells need no clearing: a window is only
//   read once enough prices have entered to fill it.
// ----------------------------------------------------------------------------
module sma_crossover_signal_top
  import sma_pkg::*;
#(
  parameter int HISTORY_DEPTH = 64,
  parameter int PRICE_WIDTH   = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  sma_price_if.sink    in_if,
  sma_signal_if.source out_if,
  sma_cfg_if.sink      cfg_if
);

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W = PRICE_WIDTH + IDX_W;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 2);
  localparam int PW    = ((CFG_W > CNT_W) ? CFG_W : CNT_W) + 1;

  logic adv;
  logic in_take;

  logic [CFG_W-1:0] short_per_r;
  logic [CFG_W-1:0] long_per_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic v0_r, v1_r, v2_r, out_valid_r;
  logic signed [SIG_W-1:0] sig_r;
  logic signed [SIG_W-1:0] sig_w;

  logic [SUM_W-1:0] sum_w [HISTORY_DEPTH];
  logic [SUM_W-1:0] price_ext;

  logic [PW-1:0]    sp_cl, lp_cl, cnt_ext;
  logic [IDX_W-1:0] sp_tap, lp_tap;
  logic [SUM_W-1:0] short_sel, long_sel;

  logic [SUM_W-1:0] short_sum_r, long_sum_r;
  logic [CFG_W-1:0] sp_r, lp_r;
  logic             active_r;

  // Whole pipeline moves unless a result waits on a stalled receiver
  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv;
  assign in_take     = in_if.valid && adv;
  assign cfg_if.ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_per_r <= SHORT_PERIOD_RST;
      long_per_r  <= LONG_PERIOD_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_SHORT_PERIOD: short_per_r <= cfg_if.data;
        REG_LONG_PERIOD:  long_per_r  <= cfg_if.data;
        default:          ;
      endcase
    end
  end

  // Saturating sample count
  always_comb begin
    count_nxt = count_r;
    if (in_take && (count_r < CNT_W'(HISTORY_DEPTH + 1))) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // Prefix sum chain: cell 0 holds the newest price alone
  assign price_ext = SUM_W'(in_if.price);

  for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
    logic [SUM_W-1:0] prev;
    if (k == 0) begin : g_head
      assign prev = '0;
    end else begin : g_link
      assign prev = sum_w[k-1];
    end
    sma_cell #(.SUM_W(SUM_W)) u_cell (
      .clk        (clk),
      .shift_en   (in_take),
      .price_i    (price_ext),
      .sum_prev_i (prev),
      .sum_o      (sum_w[k])
    );
  end

  // Clamp periods to 1..HISTORY_DEPTH
  always_comb begin
    sp_cl = PW'(short_per_r);
    lp_cl = PW'(long_per_r);
    if (sp_cl == '0) sp_cl = PW'(1);
    if (lp_cl == '0) lp_cl = PW'(1);
    if (sp_cl > PW'(HISTORY_DEPTH)) sp_cl = PW'(HISTORY_DEPTH);
    if (lp_cl > PW'(HISTORY_DEPTH)) lp_cl = PW'(HISTORY_DEPTH);
  end

  assign cnt_ext = PW'(count_r);
  assign sp_tap  = IDX_W'(sp_cl - PW'(1));
  assign lp_tap  = IDX_W'(lp_cl - PW'(1));

  // Pick the cell whose prefix covers each window
  always_comb begin
    short_sel = '0;
    long_sel  = '0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (sp_tap == IDX_W'(k)) short_sel = short_sel | sum_w[k];
      if (lp_tap == IDX_W'(k)) long_sel  = long_sel  | sum_w[k];
    end
  end

  // Register the window sums; an unfilled window counts as zero
  always_ff @(posedge clk) begin
    if (adv) begin
      short_sum_r <= (cnt_ext >= sp_cl) ? short_sel : '0;
      long_sum_r  <= (cnt_ext >= lp_cl) ? long_sel  : '0;
      sp_r        <= CFG_W'(sp_cl);
      lp_r        <= CFG_W'(lp_cl);
      active_r    <= (cnt_ext > lp_cl);
    end
  end

  sma_cmp #(.SUM_W(SUM_W)) u_cmp (
    .clk         (clk),
    .adv         (adv),
    .short_sum_i (short_sum_r),
    .long_sum_i  (long_sum_r),
    .short_per_i (sp_r),
    .long_per_i  (lp_r),
    .active_i    (active_r),
    .sig_o       (sig_w)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      sig_r <= sig_w;
    end
  end

  // Stage valid bits and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (adv) begin
        v0_r        <= in_if.valid;
        v1_r        <= v0_r;
        v2_r        <= v1_r;
        out_valid_r <= v2_r;
      end
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.signal = sig_r;

endmodule

[tb/sv/sma_crossover_signal_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_crossover_signal_top_tb
// Self-checking bench for the moving average crossover block. Each price
// request is predicted at acceptance by a local copy of the ring, the window
// sums and the period registers; signal requests are compared in order.
// Directed extremes and period clamping come first, then random price traffic
// under shifting period settings and idle profiles, and last a long receiver hold-off.
// ----------------------------------------------------------------------------
module sma_crossover_signal_top_tb;
  import sma_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RING_DEPTH   = 64;
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int PRICE_W      = 32;
  localparam int PIPE_LATENCY = 4;
  localparam int HOLD_CYCLES  = 250;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SEG_ITEMS    = 90;

  typedef enum int {PRICE_WIDE, PRICE_WALK, PRICE_FLAT, PRICE_RAIL} price_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  sma_price_if #(.PRICE_WIDTH(PRICE_W)) in_if ();
  sma_signal_if                         out_if ();
  sma_cfg_if                            cfg_if ();

  sma_crossover_signal_top #(
    .HISTORY_DEPTH(RING_DEPTH),
    .PRICE_WIDTH  (PRICE_W)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  // Local copy of the block state
  logic [PRICE_W-1:0] price_ring [RING_DEPTH];
  logic [RING_AW-1:0] ring_wr;
  logic [6:0]         seen_count;
  logic [CFG_W-1:0]   short_len;
  logic [CFG_W-1:0]   long_len;

  logic signed [SIG_W-1:0] signal_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int prices_sent   = 0;
  int reg_writes    = 0;
  int n_above       = 0;
  int n_below       = 0;
  int n_level       = 0;
  int cycle_count   = 0;
  int hold_reqs     = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  // Period sweep for the random traffic, extremes first
  int sweep_short [8] = '{1, 64, 0, 127, 2, 10, 16, 64};
  int sweep_long  [8] = '{64, 1, 127, 0, 3, 50, 16, 64};

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sma_crossover_signal_top_tb: FAIL");
      $finish;
    end
  end

  // Hold the result channel off for a long stretch on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  function automatic int unsigned clamp_len(input logic [CFG_W-1:0] p);
    if (p == '0) return 1;
    if (p > CFG_W'(RING_DEPTH)) return RING_DEPTH;
    return p;
  endfunction

  // Sum of the newest n prices in the ring
  function automatic logic [63:0] window_total(input int unsigned n);
    logic [63:0]        acc;
    logic [RING_AW-1:0] idx;
    acc = '0;
    idx = ring_wr;
    for (int unsigned k = 0; k < n; k++) begin
      idx = idx - 1'b1;
      acc = acc + price_ring[idx];
    end
    return acc;
  endfunction

  // Advance the local state by one price and return the expected signal
  function automatic logic signed [SIG_W-1:0] predict_signal(input logic [PRICE_W-1:0] p);
    int unsigned sp;
    int unsigned lp;
    logic [63:0] short_sum;
    logic [63:0] long_sum;
    logic [63:0] lhs;
    logic [63:0] rhs;
    sp = clamp_len(short_len);
    lp = clamp_len(long_len);
    price_ring[ring_wr] = p;
    ring_wr = ring_wr + 1'b1;
    if (seen_count < 7'(RING_DEPTH + 1)) seen_count = seen_count + 1'b1;
    short_sum = (seen_count >= sp) ? window_total(sp) : 64'd0;
    long_sum  = (seen_count >= lp) ? window_total(lp) : 64'd0;
    if (seen_count <= lp) return SIG_NONE;
    // compare averages exactly by cross-multiplying with the periods
    lhs = short_sum * 64'(lp);
    rhs = long_sum * 64'(sp);
    if (lhs > rhs) return SIG_ABOVE;
    if (lhs < rhs) return SIG_BELOW;
    return SIG_NONE;
  endfunction

  // Offer one price, with an optional gap before it; valid stays high after
  task automatic send_price(input logic [PRICE_W-1:0] p);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.price <= p;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    signal_q.insert(signal_q.size(), predict_signal(p));
    prices_sent++;
  endtask

  // Pause the sender until every pending signal has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (signal_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // One register write; valid stays high so writes can run back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_SHORT_PERIOD: short_len = val;
      REG_LONG_PERIOD:  long_len  = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_periods(input logic [CFG_W-1:0] sp, input logic [CFG_W-1:0] lp);
    write_reg(REG_SHORT_PERIOD, sp);
    write_reg(REG_LONG_PERIOD, lp);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_segment(input price_mode_t mode, input int count);
    logic [PRICE_W-1:0] level;
    int                 drift;
    level = $urandom;
    drift = 0;
    for (int i = 0; i < count; i++) begin
      case (mode)
        PRICE_WIDE: level = $urandom;
        PRICE_WALK: begin
          // trending walk with occasional turns, so the averages cross
          if ($urandom_range(31) == 0) drift = int'($urandom_range(100)) - 50;
          level = level + PRICE_W'(drift + int'($urandom_range(40)) - 20);
        end
        PRICE_FLAT: if ($urandom_range(15) == 0) level = $urandom;
        PRICE_RAIL: level = $urandom_range(1) ? '1 : '0;
        default: ;
      endcase
      send_price(level);
    end
  endtask

  // Extreme prices under the reset periods
  task automatic test_price_extremes();
    send_price(32'h0000_0000);
    send_price(32'hFFFF_FFFF);
    send_price(32'h0000_0001);
    send_price(32'h8000_0000);
    send_price(32'h7FFF_FFFF);
    send_price(32'hAAAA_AAAA);
    send_price(32'h5555_5555);
    drain();
  endtask

  // Zero and oversized periods, writes to unknown indexes, changes between drained bursts
  task automatic test_period_clamps();
    write_reg(CFG_IDX_W'(2), CFG_W'(127));
    write_reg('1, CFG_W'(0));
    set_periods(CFG_W'(0), CFG_W'(1));
    send_price(32'hFFFF_FFFF);
    send_price(32'h0000_0000);
    send_price(32'h0000_0005);
    drain();
    set_periods(CFG_W'(1), CFG_W'(2));
    send_price(32'hFFFF_FFFF);
    send_price(32'h0000_0000);
    send_price(32'hFFFF_FFFF);
    send_price(32'hFFFF_FFFF);
    send_price(32'h0000_0000);
    drain();
    set_periods(CFG_W'(127), CFG_W'(64));
    send_price(32'h0000_0000);
    send_price(32'hFFFF_FFFF);
    send_price(32'h1234_5678);
    drain();
    set_periods(CFG_W'(2), CFG_W'(127));
    send_price(32'hFFFF_FFFF);
    send_price(32'h0000_0000);
    drain();
  endtask

  // Random prices across period settings and idle profiles
  task automatic test_random_traffic();
    int seg;
    seg = 0;
    for (int prof = 0; prof < 3; prof++) begin
      case (prof)
        0:       begin send_idle_pct = 35; recv_idle_pct = 81; end
        1:       begin send_idle_pct = 81; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int s = 0; s < 4; s++) begin
        drain();
        if (seg < 8) begin
          set_periods(CFG_W'(sweep_short[seg]), CFG_W'(sweep_long[seg]));
        end else begin
          set_periods(CFG_W'($urandom_range(127)), CFG_W'($urandom_range(127)));
        end
        run_segment(price_mode_t'(s), SEG_ITEMS);
        seg++;
      end
    end
    drain();
  endtask

  // Long receiver hold-off while the sender keeps offering prices
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_periods(CFG_W'(3), CFG_W'(12));
    hold_reqs++;
    run_segment(PRICE_WALK, 60);
    drain();
  endtask

  // Accept and check signal requests, then pick the next ready level
  initial begin
    logic signed [SIG_W-1:0] want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (signal_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected signal, expected none actual %0d",
                   $time, $signed(out_if.signal));
        end else begin
          want = signal_q.pop_front();
          if (out_if.signal !== want) begin
            fail_count++;
            $display("%0t: signal mismatch, expected %0d actual %0d",
                     $time, want, $signed(out_if.signal));
          end
          case (want)
            SIG_ABOVE: n_above++;
            SIG_BELOW: n_below++;
            default:   n_level++;
          endcase
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.price  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    for (int i = 0; i < RING_DEPTH; i++) price_ring[i] = '0;
    ring_wr    = '0;
    seen_count = '0;
    short_len  = SHORT_PERIOD_RST;
    long_len   = LONG_PERIOD_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_price_extremes();
    test_period_clamps();
    test_random_traffic();
    test_output_backpressure();
    drain();

    $display("Run covered %0d prices and %0d register writes, including clamped periods",
             prices_sent, reg_writes);
    $display("Signals seen: %0d above, %0d below, %0d level; %0d long output hold-offs",
             n_above, n_below, n_level, hold_served);
    if (fail_count == 0) begin
      $display("sma_crossover_signal_top_tb: PASS");
    end else begin
      $display("sma_crossover_signal_top_tb: FAIL");
    end
    $finish;
  end

endmodule
